@@ rtl/scancode_to_cp437_translator_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Scan code translator assertion macros
// Shared assertion forms used by the translator modules.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_TO_CP437_TRANSLATOR_UNIT_MACROS_SVH
`define SCANCODE_TO_CP437_TRANSLATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define S2C_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define S2C_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

@@ rtl/s2c_pkg.sv @@
// ----------------------------------------------------------------------------
// Scan code translator package
// Key codes, character constants, layout tables and shared types.
// ----------------------------------------------------------------------------
package s2c_pkg;

   localparam int KEY_COUNT = 80;
   localparam int KEY_W = 7;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KEY_W-1:0] KEY_LSHIFT = 7'h2A;
   localparam logic [KEY_W-1:0] KEY_RSHIFT = 7'h36;
   localparam logic [KEY_W-1:0] KEY_CTRL = 7'h1D;
   localparam logic [KEY_W-1:0] KEY_ALTGR = 7'h38;
   localparam logic [KEY_W-1:0] KEY_CAPS = 7'h3A;

   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_ACUTE = 8'hB4;
   localparam logic [7:0] CHAR_CTRL_C = 8'h03;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_C = 8'h63;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_C = 8'h43;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_BIT = 8'h20;

   localparam logic [7:0] PLAIN_TABLE [KEY_COUNT] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
      8'h39, 8'h30, 8'h27, 8'hAD, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
      8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h60, 8'h2B, 8'h0A, 8'h00,
      8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'hA4,
      8'hB4, 8'hBA, 8'h00, 8'hE7, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
      8'h6D, 8'h2C, 8'h2E, 8'h2D, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37, 8'h38, 8'h39,
      8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31, 8'h32, 8'h33, 8'h30, 8'h2E
   };

   localparam logic [7:0] SHIFT_TABLE [KEY_COUNT] = '{
      8'h00, 8'h1B, 8'h21, 8'h22, 8'hB7, 8'h24, 8'h25, 8'h26, 8'h2F, 8'h28,
      8'h29, 8'h3D, 8'h3F, 8'hAD, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
      8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h5E, 8'h2A, 8'h0A, 8'h00,
      8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'hA5,
      8'hA8, 8'hF8, 8'h00, 8'h43, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
      8'h4D, 8'h3B, 8'h3A, 8'h5F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37, 8'h38, 8'h39,
      8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31, 8'h32, 8'h33, 8'h30, 8'h2E
   };

   localparam logic [7:0] ALTGR_TABLE [KEY_COUNT] = '{
      8'h00, 8'h00, 8'h00, 8'h40, 8'h23, 8'h7E, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h91, 8'h00, 8'h82, 8'h00,
      8'h00, 8'h00, 8'hA3, 8'hA1, 8'hA2, 8'h00, 8'h5B, 8'h5D, 8'h00, 8'h00,
      8'hA0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h7B, 8'h00, 8'h00, 8'h7D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   typedef struct packed {
      logic       two;
      logic [7:0] first;
      logic [7:0] second;
   } s2c_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } s2c_qstat_type;

   function automatic logic [7:0] accented(input logic [7:0] ch);
      logic [7:0] acc;
      unique case (ch)
         8'h61: acc = 8'hA0;
         8'h65: acc = 8'h82;
         8'h69: acc = 8'hA1;
         8'h6F: acc = 8'hA2;
         8'h75: acc = 8'hA3;
         8'h41: acc = 8'hB5;
         8'h45: acc = 8'h90;
         8'h49: acc = 8'hD6;
         8'h4F: acc = 8'hE0;
         8'h55: acc = 8'hE9;
         default: acc = CHAR_NUL;
      endcase
      return acc;
   endfunction

endpackage

@@ rtl/scancode_to_cp437_translator_unit.sv @@
// ----------------------------------------------------------------------------
// Scan code to CP437 translator
// Translates set-1 keyboard scan codes into CP437 characters.
// ----------------------------------------------------------------------------
// The request channel takes one scan code byte per accepted request, with
// req_valid high and req_stall low at a rising edge. The front end updates
// the shift, ctrl, AltGr, caps lock and dead-key state in that same cycle,
// so a new request can be accepted every cycle while the queue has room.
// Each request yields zero, one or two characters on the response channel;
// rsp_last marks the final character of a request. A first character is
// written into the queue and is then loaded into the output register,
// from which the receiver takes it. The second one of a pair is held in
// a register and follows once the first has left, so the response port
// moves one character per cycle while rsp_stall is low.
// When the receiver raises rsp_stall, the output register holds its
// character, the two-entry queue fills and req_stall rises once it is full.
// Synchronous reset clears all modifier and dead-key state, empties the
// queue and drops any character not yet delivered.
// ----------------------------------------------------------------------------
module scancode_to_cp437_translator_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_scan_code,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_char_code,
   output logic       rsp_last
);

   s2c_pkg::s2c_qstat_type qstat;
   s2c_pkg::s2c_entry_type push_entry;
   s2c_pkg::s2c_entry_type head_entry;
   logic                   push;
   logic                   pop;

   s2c_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_scan_code (req_scan_code),
      .qstat         (qstat),
      .push          (push),
      .entry         (push_entry)
   );

   s2c_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .qstat      (qstat)
   );

   s2c_back u_back (
      .clock         (clock),
      .reset         (reset),
      .qstat         (qstat),
      .head_entry    (head_entry),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

endmodule

@@ rtl/s2c_front.sv @@
// ----------------------------------------------------------------------------
// Scan code translator front end
// Tracks modifier and dead-key state and turns each scan code that yields
// characters into a queue entry holding the one or two it produces.
// ----------------------------------------------------------------------------
`include "scancode_to_cp437_translator_unit_macros.svh"

module s2c_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_scan_code,
   input  s2c_pkg::s2c_qstat_type qstat,
   output logic                   push,
   output s2c_pkg::s2c_entry_type entry
);

   logic shift_ff, shift_in;
   logic ctrl_ff, ctrl_in;
   logic altgr_ff, altgr_in;
   logic caps_ff, caps_in;
   logic accent_ff, accent_in;

   logic                      accept;
   logic                      release_code;
   logic [s2c_pkg::KEY_W-1:0] key;
   logic                      in_table;
   logic [s2c_pkg::KEY_W-1:0] idx;
   logic [7:0]                altgr_ch;
   logic [7:0]                base_ch;
   logic [7:0]                case_ch;
   logic [7:0]                ch;
   logic [7:0]                acc_ch;
   logic                      is_letter;

   assign req_stall    = qstat.full;
   assign accept       = req_valid && !qstat.full;
   assign release_code = req_scan_code[7];
   assign key          = req_scan_code[6:0];
   assign in_table     = (req_scan_code < 8'(s2c_pkg::KEY_COUNT));
   assign idx          = in_table ? key : '0;

   always_comb begin
      altgr_ch = s2c_pkg::ALTGR_TABLE[idx];
      if (altgr_ff && (altgr_ch != s2c_pkg::CHAR_NUL)) begin
         base_ch = altgr_ch;
      end else if (shift_ff) begin
         base_ch = s2c_pkg::SHIFT_TABLE[idx];
      end else begin
         base_ch = s2c_pkg::PLAIN_TABLE[idx];
      end
      is_letter = ((base_ch >= s2c_pkg::CHAR_LOWER_A) && (base_ch <= s2c_pkg::CHAR_LOWER_Z))
         || ((base_ch >= s2c_pkg::CHAR_UPPER_A) && (base_ch <= s2c_pkg::CHAR_UPPER_Z));
      case_ch = (!altgr_ff && caps_ff && is_letter) ? (base_ch ^ s2c_pkg::CASE_BIT) : base_ch;
      if (ctrl_ff && ((case_ch == s2c_pkg::CHAR_LOWER_C)
            || (case_ch == s2c_pkg::CHAR_UPPER_C))) begin
         ch = s2c_pkg::CHAR_CTRL_C;
      end else begin
         ch = case_ch;
      end
      acc_ch = s2c_pkg::accented(ch);
   end

   always_comb begin
      shift_in  = shift_ff;
      ctrl_in   = ctrl_ff;
      altgr_in  = altgr_ff;
      caps_in   = caps_ff;
      accent_in = accent_ff;
      push      = 1'b0;
      entry     = '0;
      if (accept) begin
         priority if (release_code) begin
            if ((key == s2c_pkg::KEY_LSHIFT) || (key == s2c_pkg::KEY_RSHIFT)) begin
               shift_in = 1'b0;
            end
            if (key == s2c_pkg::KEY_CTRL) begin
               ctrl_in = 1'b0;
            end
            if (key == s2c_pkg::KEY_ALTGR) begin
               altgr_in = 1'b0;
            end
         end else if ((key == s2c_pkg::KEY_LSHIFT) || (key == s2c_pkg::KEY_RSHIFT)) begin
            shift_in = 1'b1;
         end else if (key == s2c_pkg::KEY_CTRL) begin
            ctrl_in = 1'b1;
         end else if (key == s2c_pkg::KEY_ALTGR) begin
            altgr_in = 1'b1;
         end else if (key == s2c_pkg::KEY_CAPS) begin
            caps_in = !caps_ff;
         end else if (!in_table || (ch == s2c_pkg::CHAR_NUL)) begin
            push = 1'b0;
         end else if (accent_ff) begin
            accent_in    = 1'b0;
            push         = 1'b1;
            entry.two    = (acc_ch == s2c_pkg::CHAR_NUL);
            entry.first  = (acc_ch == s2c_pkg::CHAR_NUL) ? s2c_pkg::CHAR_ACUTE : acc_ch;
            entry.second = ch;
         end else if (!altgr_ff && (ch == s2c_pkg::CHAR_ACUTE)) begin
            accent_in = 1'b1;
         end else begin
            push        = 1'b1;
            entry.first = ch;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff  <= 1'b0;
         ctrl_ff   <= 1'b0;
         altgr_ff  <= 1'b0;
         caps_ff   <= 1'b0;
         accent_ff <= 1'b0;
      end else begin
         shift_ff  <= shift_in;
         ctrl_ff   <= ctrl_in;
         altgr_ff  <= altgr_in;
         caps_ff   <= caps_in;
         accent_ff <= accent_in;
      end
   end

   `S2C_ASSERT_SAME(a_push_room, clock, reset, push, !qstat.full)
   `S2C_ASSERT_NEXT(a_pair_clears_accent, clock, reset, push && entry.two, !accent_ff)

endmodule

@@ rtl/s2c_queue.sv @@
// ----------------------------------------------------------------------------
// Scan code translator queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
`include "scancode_to_cp437_translator_unit_macros.svh"

module s2c_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  s2c_pkg::s2c_entry_type push_entry,
   input  logic                   pop,
   output s2c_pkg::s2c_entry_type head_entry,
   output s2c_pkg::s2c_qstat_type qstat
);

   s2c_pkg::s2c_entry_type            store_ff [s2c_pkg::QUEUE_DEPTH];
   logic [s2c_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [s2c_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [s2c_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;

   localparam logic [s2c_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      s2c_pkg::QUEUE_PTR_W'(s2c_pkg::QUEUE_DEPTH - 1);
   localparam logic [s2c_pkg::QUEUE_CNT_W-1:0] FULL_COUNT =
      s2c_pkg::QUEUE_CNT_W'(s2c_pkg::QUEUE_DEPTH);

   assign qstat.full  = (count_ff == FULL_COUNT);
   assign qstat.empty = (count_ff == '0);
   assign head_entry  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `S2C_ASSERT_SAME(a_pop_nonempty, clock, reset, pop, count_ff != '0)

endmodule

@@ rtl/s2c_back.sv @@
// ----------------------------------------------------------------------------
// Scan code translator back end
// Drains queue entries into the registered response port, one character
// per cycle while unstalled, holding a pair's second until the first leaves.
// ----------------------------------------------------------------------------
`include "scancode_to_cp437_translator_unit_macros.svh"

module s2c_back (
   input  logic                   clock,
   input  logic                   reset,
   input  s2c_pkg::s2c_qstat_type qstat,
   input  s2c_pkg::s2c_entry_type head_entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_char_code,
   output logic                   rsp_last
);

   logic       valid_ff, valid_in;
   logic       pend_ff, pend_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic [7:0] second_ff, second_in;
   logic       out_free;

   assign out_free      = !valid_ff || !rsp_stall;
   assign pop           = out_free && !pend_ff && !qstat.empty;
   assign rsp_valid     = valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;

   always_comb begin
      valid_in  = valid_ff;
      pend_in   = pend_ff;
      char_in   = char_ff;
      last_in   = last_ff;
      second_in = second_ff;
      if (out_free) begin
         priority if (pend_ff) begin
            valid_in = 1'b1;
            pend_in  = 1'b0;
            char_in  = second_ff;
            last_in  = 1'b1;
         end else if (!qstat.empty) begin
            valid_in  = 1'b1;
            pend_in   = head_entry.two;
            char_in   = head_entry.first;
            last_in   = !head_entry.two;
            second_in = head_entry.second;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff   <= char_in;
      last_ff   <= last_in;
      second_ff <= second_in;
   end

   `S2C_ASSERT_SAME(a_pend_behind_first, clock, reset, pend_ff, valid_ff && !last_ff)

endmodule

@@ tb/scancode_to_cp437_translator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Scan code to CP437 translator testbench
// Feeds set-1 scan codes through directed keyboard sequences and random
// typing, predicts the CP437 characters from its own layout tables and
// modifier state, and checks every response in order against them.
// ----------------------------------------------------------------------------
module scancode_to_cp437_translator_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_KEYS = 80;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 6;

   localparam logic [7:0] SC_RELEASE = 8'h80;
   localparam logic [7:0] SC_LSHIFT = 8'h2A;
   localparam logic [7:0] SC_RSHIFT = 8'h36;
   localparam logic [7:0] SC_CTRL = 8'h1D;
   localparam logic [7:0] SC_RIGHT_ALT = 8'h38;
   localparam logic [7:0] SC_CAPS = 8'h3A;
   localparam logic [7:0] SC_ACUTE = 8'h28;
   localparam logic [7:0] SC_Q = 8'h10;
   localparam logic [7:0] SC_E = 8'h12;
   localparam logic [7:0] SC_A = 8'h1E;
   localparam logic [7:0] SC_S = 8'h1F;
   localparam logic [7:0] SC_C = 8'h2E;
   localparam logic [7:0] SC_F1 = 8'h3B;

   localparam logic [7:0] CH_NONE = 8'h00;
   localparam logic [7:0] CH_ACUTE = 8'hB4;
   localparam logic [7:0] CH_ETX = 8'h03;

   localparam logic [7:0] VOWEL_KEYS [5] = '{8'h1E, 8'h12, 8'h17, 8'h18, 8'h16};

   localparam logic [7:0] LOWER_MAP [NUM_KEYS] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
      8'h39, 8'h30, 8'h27, 8'hAD, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
      8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h60, 8'h2B, 8'h0A, 8'h00,
      8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'hA4,
      8'hB4, 8'hBA, 8'h00, 8'hE7, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
      8'h6D, 8'h2C, 8'h2E, 8'h2D, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37, 8'h38, 8'h39,
      8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31, 8'h32, 8'h33, 8'h30, 8'h2E
   };

   localparam logic [7:0] UPPER_MAP [NUM_KEYS] = '{
      8'h00, 8'h1B, 8'h21, 8'h22, 8'hB7, 8'h24, 8'h25, 8'h26, 8'h2F, 8'h28,
      8'h29, 8'h3D, 8'h3F, 8'hAD, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
      8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h5E, 8'h2A, 8'h0A, 8'h00,
      8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'hA5,
      8'hA8, 8'hF8, 8'h00, 8'h43, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
      8'h4D, 8'h3B, 8'h3A, 8'h5F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37, 8'h38, 8'h39,
      8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31, 8'h32, 8'h33, 8'h30, 8'h2E
   };

   localparam logic [7:0] ALT_MAP [NUM_KEYS] = '{
      8'h00, 8'h00, 8'h00, 8'h40, 8'h23, 8'h7E, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h91, 8'h00, 8'h82, 8'h00,
      8'h00, 8'h00, 8'hA3, 8'hA1, 8'hA2, 8'h00, 8'h5B, 8'h5D, 8'h00, 8'h00,
      8'hA0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h7B, 8'h00, 8'h00, 8'h7D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   typedef struct {
      logic [7:0] code;
      logic       last;
   } cp437_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_scan_code = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_char_code;
   logic       rsp_last;

   logic shift_down = 1'b0;
   logic ctrl_down = 1'b0;
   logic altgr_down = 1'b0;
   logic caps_lock = 1'b0;
   logic acute_armed = 1'b0;

   cp437_char_type typed_chars [$];
   logic           idling_on = 1'b1;
   int             error_count = 0;
   int             quiet_cycles = 0;

   scancode_to_cp437_translator_unit u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_scan_code (req_scan_code),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [7:0] accent_vowel(input logic [7:0] ch);
      case (ch)
         8'h61: return 8'hA0;
         8'h65: return 8'h82;
         8'h69: return 8'hA1;
         8'h6F: return 8'hA2;
         8'h75: return 8'hA3;
         8'h41: return 8'hB5;
         8'h45: return 8'h90;
         8'h49: return 8'hD6;
         8'h4F: return 8'hE0;
         8'h55: return 8'hE9;
         default: return CH_NONE;
      endcase
   endfunction

   function automatic void push_char(input logic [7:0] code, input logic last);
      cp437_char_type item;
      item.code = code;
      item.last = last;
      typed_chars.push_back(item);
   endfunction

   function automatic void translate_scan_code(input logic [7:0] sc);
      logic [7:0] key;
      logic [7:0] ch;
      logic [7:0] acc;
      key = sc & ~SC_RELEASE;
      if (sc[7]) begin
         if (key == SC_LSHIFT || key == SC_RSHIFT) shift_down = 1'b0;
         if (key == SC_CTRL) ctrl_down = 1'b0;
         if (key == SC_RIGHT_ALT) altgr_down = 1'b0;
         return;
      end
      if (sc == SC_LSHIFT || sc == SC_RSHIFT) begin
         shift_down = 1'b1;
         return;
      end
      if (sc == SC_CTRL) begin
         ctrl_down = 1'b1;
         return;
      end
      if (sc == SC_RIGHT_ALT) begin
         altgr_down = 1'b1;
         return;
      end
      if (sc == SC_CAPS) begin
         caps_lock = ~caps_lock;
         return;
      end
      if (sc >= NUM_KEYS) return;

      if (altgr_down && ALT_MAP[sc] != CH_NONE) ch = ALT_MAP[sc];
      else if (shift_down) ch = UPPER_MAP[sc];
      else ch = LOWER_MAP[sc];

      if (!altgr_down && caps_lock) begin
         if (ch >= "a" && ch <= "z") ch = ch - 8'd32;
         else if (ch >= "A" && ch <= "Z") ch = ch + 8'd32;
      end
      if (ctrl_down && (ch == "c" || ch == "C")) ch = CH_ETX;
      if (ch == CH_NONE) return;

      if (acute_armed) begin
         acute_armed = 1'b0;
         acc = accent_vowel(ch);
         if (acc != CH_NONE) begin
            push_char(acc, 1'b1);
         end else begin
            push_char(CH_ACUTE, 1'b0);
            push_char(ch, 1'b1);
         end
         return;
      end
      if (!altgr_down && ch == CH_ACUTE) begin
         acute_armed = 1'b1;
         return;
      end
      push_char(ch, 1'b1);
   endfunction

   function automatic logic [7:0] random_keystroke();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return 8'($urandom_range(1, NUM_KEYS - 1));
      if (pick < 55) return SC_ACUTE;
      if (pick < 62) return VOWEL_KEYS[$urandom_range(0, 4)];
      if (pick < 71) begin
         case ($urandom_range(0, 3))
            0: return SC_LSHIFT;
            1: return SC_RSHIFT;
            2: return SC_CTRL;
            default: return SC_RIGHT_ALT;
         endcase
      end
      if (pick < 82) begin
         case ($urandom_range(0, 3))
            0: return SC_LSHIFT | SC_RELEASE;
            1: return SC_RSHIFT | SC_RELEASE;
            2: return SC_CTRL | SC_RELEASE;
            default: return SC_RIGHT_ALT | SC_RELEASE;
         endcase
      end
      if (pick < 85) return SC_CAPS;
      if (pick < 91) return SC_RELEASE | 8'($urandom_range(0, 127));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_scan_code(input logic [7:0] code);
      while (idling_on && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_scan_code <= code;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      translate_scan_code(code);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (typed_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_plain_and_ignored();
      send_scan_code(SC_Q);
      send_scan_code(8'h00);
      send_scan_code(8'h4F);
      send_scan_code(8'h50);
      send_scan_code(8'hFF);
      send_scan_code(SC_RELEASE);
      send_scan_code(SC_A | SC_RELEASE);
   endtask

   task automatic test_modifiers();
      send_scan_code(SC_LSHIFT);
      send_scan_code(SC_Q);
      send_scan_code(SC_LSHIFT | SC_RELEASE);
      send_scan_code(SC_CAPS);
      send_scan_code(SC_A);
      send_scan_code(SC_CAPS);
      send_scan_code(SC_CTRL);
      send_scan_code(SC_C);
      send_scan_code(SC_CTRL | SC_RELEASE);
      send_scan_code(SC_RIGHT_ALT);
      send_scan_code(SC_ACUTE);
      send_scan_code(SC_RIGHT_ALT | SC_RELEASE);
   endtask

   task automatic test_dead_key();
      send_scan_code(SC_ACUTE);
      send_scan_code(SC_F1);
      send_scan_code(SC_E);
      send_scan_code(SC_ACUTE);
      send_scan_code(SC_ACUTE);
      send_scan_code(SC_ACUTE);
      send_scan_code(SC_S);
   endtask

   task automatic test_random_typing(input int count);
      repeat (count) send_scan_code(random_keystroke());
   endtask

   task automatic test_back_to_back(input int count);
      idling_on = 1'b0;
      repeat (count) send_scan_code(random_keystroke());
      idling_on = 1'b1;
   endtask

   task automatic test_drain_pauses(input int bursts);
      repeat (bursts) begin
         repeat ($urandom_range(1, 20)) send_scan_code(random_keystroke());
         wait_for_drain();
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= idling_on && ($urandom_range(0, 99) < 7);
   end

   always @(posedge clock) begin
      cp437_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (typed_chars.size() == 0) begin
            $error("unexpected response: char_code %02h last %0b", rsp_char_code, rsp_last);
            error_count++;
         end else begin
            want = typed_chars.pop_front();
            if (rsp_char_code !== want.code) begin
               $error("char_code: expected %02h, actual %02h", want.code, rsp_char_code);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_plain_and_ignored();
      test_modifiers();
      test_dead_key();
      test_random_typing(600);
      test_back_to_back(200);
      test_drain_pauses(12);
      test_random_typing(80);
      wait_for_drain();
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/s2c_pkg.sv
rtl/s2c_front.sv
rtl/s2c_queue.sv
rtl/s2c_back.sv
rtl/scancode_to_cp437_translator_unit.sv
tb/scancode_to_cp437_translator_unit_tb.sv
